>>> rtl/ubtc_pkg.sv
// Shared constants, types and byte-class functions for the UTF-8 truncating copy.
package ubtc_pkg;

    localparam int unsigned SIZE_W        = 13;
    localparam int unsigned MAX_DEST_SIZE = 4096;
    localparam int unsigned MAX_RESULTS   = 4;
    localparam int unsigned CNT_W         = $clog2(MAX_RESULTS + 1);

    localparam logic [SIZE_W-1:0] DEST_SIZE_RESET = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] DEST_SIZE_CAP   = SIZE_W'(MAX_DEST_SIZE);

    // Byte classes
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] SURR_LEAD = 8'hED;
    localparam logic [7:0] SECOND_A0 = 8'hA0;
    localparam logic [7:0] SECOND_90 = 8'h90;

    // One item's worth of results, first result in bytes[0].
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        term;   // last result is the terminator
    } t_burst;

    // Sequence length opened by a byte; 1 for ASCII and anything that is not a lead.
    function automatic logic [2:0] unit_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd1;
        if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
        if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
        if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
        return len;
    endfunction

    // Reject overlong, surrogate and above-range second bytes.
    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] s);
        logic ok;
        ok = 1'b1;
        if (lead == LEAD3_LO  && s <  SECOND_A0) ok = 1'b0;
        if (lead == SURR_LEAD && s >= SECOND_A0) ok = 1'b0;
        if (lead == LEAD4_LO  && s <  SECOND_90) ok = 1'b0;
        if (lead == LEAD4_HI  && s >= SECOND_90) ok = 1'b0;
        return ok;
    endfunction

endpackage

>>> rtl/ubtc_core.sv
// Sequence tracker: held bytes, fill count and stop flag, producing one burst per byte.
module ubtc_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [7:0]                   i_byte,
    input  logic [ubtc_pkg::SIZE_W-1:0]  i_dest_size,
    output ubtc_pkg::t_burst             o_burst
);

    logic [1:0]                    r_hc, n_hc;
    logic [7:0]                    r_held [3];
    logic [7:0]                    n_held [3];
    logic [2:0]                    r_exp, n_exp;
    logic [ubtc_pkg::SIZE_W-1:0]   r_bw, n_bw;
    logic                          r_stop, n_stop;

    logic [ubtc_pkg::SIZE_W-1:0]   w_eff;
    logic [ubtc_pkg::SIZE_W-1:0]   w_room;
    logic [2:0]                    w_avail;
    logic                          w_valid;

    // Effective size and free space ahead of the terminator, saturated at 4.
    always_comb begin
        w_eff  = (i_dest_size > ubtc_pkg::DEST_SIZE_CAP) ? ubtc_pkg::DEST_SIZE_CAP
                                                         : i_dest_size;
        w_room = w_eff - r_bw - ubtc_pkg::SIZE_W'(1);
        if (w_eff <= r_bw) begin
            w_avail = 3'd0;
        end else if (w_room >= ubtc_pkg::SIZE_W'(4)) begin
            w_avail = 3'd4;
        end else begin
            w_avail = w_room[2:0];
        end
        w_valid = ((i_byte & ubtc_pkg::CONT_MASK) == ubtc_pkg::CONT_TAG) &&
                  (r_hc != 2'd1 || ubtc_pkg::second_ok(r_held[0], i_byte));
    end

    always_comb begin
        logic [2:0]                  v_cnt;
        logic [1:0]                  v_m;
        logic                        v_stop;
        logic [ubtc_pkg::SIZE_W-1:0] v_bw;
        logic [2:0]                  v_avail;
        logic [2:0]                  v_len;
        n_hc    = r_hc;
        n_held  = r_held;
        n_exp   = r_exp;
        n_bw    = r_bw;
        n_stop  = r_stop;
        o_burst = '0;
        v_cnt   = 3'd0;
        v_m     = 2'd0;
        v_stop  = r_stop;
        v_bw    = r_bw;
        v_avail = w_avail;
        v_len   = 3'd1;
        if (!r_stop && r_hc != 2'd0 && w_valid) begin
            if ({1'b0, r_hc} + 3'd1 >= r_exp) begin
                // sequence complete: emit all of it or stop
                n_hc  = 2'd0;
                n_exp = 3'd1;
                if ({1'b0, r_hc} + 3'd1 <= w_avail) begin
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) < r_hc) o_burst.bytes[i] = r_held[i];
                    end
                    o_burst.bytes[r_hc] = i_byte;
                    o_burst.count       = ubtc_pkg::CNT_W'(r_hc) + ubtc_pkg::CNT_W'(1);
                    n_bw = r_bw + ubtc_pkg::SIZE_W'(r_hc) + ubtc_pkg::SIZE_W'(1);
                end else begin
                    n_stop = 1'b1;
                end
            end else begin
                n_held[r_hc] = i_byte;
                n_hc         = r_hc + 2'd1;
            end
        end else begin
            // malformed or none held: flush held bytes singly while they fit
            if (!r_stop && r_hc != 2'd0) begin
                v_m = (w_avail < {1'b0, r_hc}) ? w_avail[1:0] : r_hc;
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < v_m) o_burst.bytes[i] = r_held[i];
                end
                v_cnt   = {1'b0, v_m};
                v_stop  = (v_m != r_hc);
                v_bw    = r_bw + ubtc_pkg::SIZE_W'(v_m);
                v_avail = w_avail - {1'b0, v_m};
                n_hc    = 2'd0;
                n_exp   = 3'd1;
            end
            if (i_byte == 8'd0) begin
                if (w_eff != '0) begin
                    o_burst.bytes[v_cnt[1:0]] = 8'd0;
                    o_burst.term              = 1'b1;
                    v_cnt                     = v_cnt + 3'd1;
                end
                n_hc   = 2'd0;
                n_exp  = 3'd1;
                n_bw   = '0;
                n_stop = 1'b0;
            end else if (v_stop) begin
                n_stop = 1'b1;
                n_bw   = v_bw;
            end else begin
                v_len  = ubtc_pkg::unit_length(i_byte);
                n_bw   = v_bw;
                n_stop = 1'b0;
                if (v_len == 3'd1) begin
                    if (v_avail != 3'd0) begin
                        o_burst.bytes[v_cnt[1:0]] = i_byte;
                        v_cnt = v_cnt + 3'd1;
                        n_bw  = v_bw + ubtc_pkg::SIZE_W'(1);
                    end else begin
                        n_stop = 1'b1;
                    end
                end else begin
                    n_held[0] = i_byte;
                    n_hc      = 2'd1;
                    n_exp     = v_len;
                end
            end
            o_burst.count = ubtc_pkg::CNT_W'(v_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc   <= 2'd0;
            r_exp  <= 3'd1;
            r_bw   <= '0;
            r_stop <= 1'b0;
        end else if (i_fire) begin
            r_hc   <= n_hc;
            r_exp  <= n_exp;
            r_bw   <= n_bw;
            r_stop <= n_stop;
        end
    end

    // held bytes are only read below the fill count
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_held <= n_held;
        end
    end

endmodule

>>> rtl/ubtc_outbuf.sv
// Result register: holds one burst; hands out one word per ready cycle.
module ubtc_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ubtc_pkg::t_burst  i_burst,
    input  logic              i_tready,
    output logic              o_tvalid,
    output logic [7:0]        o_tdata,
    output logic              o_tlast,
    output logic              o_tuser,
    output logic              o_free
);

    logic [ubtc_pkg::MAX_RESULTS-1:0][7:0] r_bytes;
    logic [ubtc_pkg::CNT_W-1:0]            r_cnt;
    logic                                  r_term;
    logic                                  w_pop;

    assign w_pop    = o_tvalid && i_tready;
    assign o_tvalid = (r_cnt != '0);
    assign o_tdata  = r_bytes[0];
    assign o_tlast  = (r_cnt == ubtc_pkg::CNT_W'(1));
    assign o_tuser  = r_term && o_tlast;
    // free when empty or once the last word goes out this cycle
    assign o_free   = !o_tvalid || (o_tlast && i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_term <= 1'b0;
        end else if (i_load) begin
            r_cnt  <= i_burst.count;
            r_term <= i_burst.term;
        end else if (w_pop) begin
            r_cnt  <= r_cnt - ubtc_pkg::CNT_W'(1);
        end
    end

    // advance the burst one word per pop
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
        end else if (w_pop) begin
            r_bytes <= {8'd0, r_bytes[ubtc_pkg::MAX_RESULTS-1:1]};
        end
    end

endmodule

>>> rtl/utf8_boundary_truncating_copy.sv
// Top level of the UTF-8 boundary-safe truncating string copy.
// Source bytes of a zero-terminated string enter on the s_axis side, one byte per word; the
// copied prefix leaves on the m_axis side. The copy never splits a well-formed UTF-8 sequence
// of 2 to 4 bytes: a lead byte is held until its sequence completes or proves malformed, and
// a complete sequence goes out whole or not at all. Bytes of a malformed sequence go out one
// by one and the offending byte starts afresh. Once a unit no longer fits ahead of the
// terminator in a buffer of i_dest_size bytes (values above 4096 act as 4096), output stops
// until the zero byte; the zero byte then yields the terminator word (tuser high) unless the
// size is zero, and the block is ready for the next string. Each source byte gives zero to
// four output words; m_axis_tlast marks the last word caused by one source byte. Source bytes
// are taken one per cycle, unless held back, through an input register; all work for a byte
// is combinational from that register to the result register. The single output port drains
// one word per cycle while m_axis_tready is high; a byte releasing more than one word holds
// the next byte back until its burst drains. With a ready sink, sustained rate is one byte
// per cycle when each byte releases at most one word. Write i_dest_size only while idle.
module utf8_boundary_truncating_copy (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_dest_size_we,
    input  logic [ubtc_pkg::SIZE_W-1:0]  i_dest_size,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] in_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // [7:0] out_byte
    output logic                         m_axis_tlast,   // last_of_run
    output logic                         m_axis_tuser    // [0] is_terminator
);

    logic [ubtc_pkg::SIZE_W-1:0] r_dest_size;
    logic                        r_in_vld;
    logic [7:0]                  r_in_byte;
    logic                        w_free;
    logic                        w_fire;
    ubtc_pkg::t_burst            w_burst;

    // Move the held byte into the result register once the previous burst is drained.
    assign w_fire        = r_in_vld && w_free;
    assign s_axis_tready = !r_in_vld || w_fire;

    // Size register: taken on every write enable, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_size <= ubtc_pkg::DEST_SIZE_RESET;
        end else if (i_dest_size_we) begin
            r_dest_size <= i_dest_size;
        end
    end

    // Input register: hold a byte while the result side is busy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    ubtc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_byte      (r_in_byte),
        .i_dest_size (r_dest_size),
        .o_burst     (w_burst)
    );

    ubtc_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_burst  (w_burst),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser),
        .o_free   (w_free)
    );

`ifndef SYNTHESIS
    // The terminator is always the last word of its burst and carries a zero byte.
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'd0)
        else $error("terminator word not last or not zero");

    // A burst keeps going until its last word is taken.
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("burst broke off before its last word");

    // The input side stalls only while results are waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");
`endif

endmodule

>>> tb/utf8_copy_checker.sv
// Checker for the UTF-8 truncating copy: predicts every output word and compares it.
module utf8_copy_checker
    import ubtc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_src_valid,
    input  logic              i_src_ready,
    input  logic [7:0]        i_src_byte,
    input  logic              i_dst_valid,
    input  logic              i_dst_ready,
    input  logic [7:0]        i_dst_byte,
    input  logic              i_dst_last,
    input  logic              i_dst_term,
    output int unsigned       o_pending,
    output int unsigned       o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       term;
        logic       last;
    } dest_word_t;

    dest_word_t        words_due[$];
    dest_word_t        burst[$];
    logic [SIZE_W-1:0] buf_size;
    logic [7:0]        partial_seq [3];
    int unsigned       partial_len;
    int unsigned       seq_span;
    int unsigned       copied;
    bit                truncated;
    int unsigned       fails;

    function automatic int unsigned span_of(logic [7:0] b);
        if (b >= LEAD2_LO && b <= LEAD2_HI) return 2;
        if (b >= LEAD3_LO && b <= LEAD3_HI) return 3;
        if (b >= LEAD4_LO && b <= LEAD4_HI) return 4;
        return 1;
    endfunction

    // Reject overlong, surrogate and above-range second bytes.
    function automatic bit second_fits(logic [7:0] lead, logic [7:0] s);
        case (lead)
            LEAD3_LO:  return s >= SECOND_A0;
            SURR_LEAD: return s <  SECOND_A0;
            LEAD4_LO:  return s >= SECOND_90;
            LEAD4_HI:  return s <  SECOND_90;
            default:   return 1'b1;
        endcase
    endfunction

    function automatic int unsigned room();
        return (buf_size > MAX_DEST_SIZE) ? MAX_DEST_SIZE : buf_size;
    endfunction

    function automatic void add_word(logic [7:0] b, logic term);
        if (burst.size() < MAX_RESULTS) burst.push_back('{data: b, term: term, last: 1'b0});
    endfunction

    function automatic void clear_partial();
        partial_seq = '{default: '0};
        partial_len = 0;
        seq_span    = 1;
    endfunction

    // Write a unit whole when it leaves room for the terminator, else stop the copy.
    function automatic void write_unit(logic [3:0][7:0] unit, int unsigned len);
        int unsigned i;
        if (copied + len >= room()) begin
            truncated = 1'b1;
        end else begin
            for (i = 0; i < len; i++) add_word(unit[i], 1'b0);
            copied += len;
        end
    endfunction

    function automatic void end_string();
        if (room() != 0) add_word(8'h00, 1'b1);
        clear_partial();
        copied    = 0;
        truncated = 1'b0;
    endfunction

    // Run one source byte through the copy. A malformed sequence sends its lead out
    // alone, then the bytes held after it and the offending byte are scanned afresh.
    function automatic void copy_source_byte(logic [7:0] src);
        logic [7:0]      scan[$];
        logic [7:0]      cur;
        logic [7:0]      saved [3];
        logic [3:0][7:0] unit;
        dest_word_t      tail;
        int unsigned     n;
        int              i;
        bit              cont_ok;
        scan.push_back(src);
        while (scan.size() != 0) begin
            cur  = scan.pop_front();
            unit = '0;
            if (truncated) begin
                if (cur == 8'h00) end_string();
            end else if (partial_len == 0) begin
                if (cur == 8'h00) begin
                    end_string();
                end else if (span_of(cur) == 1) begin
                    unit[0] = cur;
                    write_unit(unit, 1);
                end else begin
                    partial_seq[0] = cur;
                    partial_len    = 1;
                    seq_span       = span_of(cur);
                end
            end else begin
                cont_ok = cur != 8'h00 && (cur & CONT_MASK) == CONT_TAG &&
                          (partial_len != 1 || second_fits(partial_seq[0], cur));
                if (cont_ok && partial_len + 1 >= seq_span) begin
                    for (i = 0; i < partial_len; i++) unit[i] = partial_seq[i];
                    unit[partial_len] = cur;
                    n = partial_len + 1;
                    clear_partial();
                    write_unit(unit, n);
                end else if (cont_ok) begin
                    partial_seq[partial_len] = cur;
                    partial_len++;
                end else begin
                    n     = partial_len;
                    saved = partial_seq;
                    clear_partial();
                    unit[0] = saved[0];
                    write_unit(unit, 1);
                    scan.push_front(cur);
                    for (i = n - 1; i >= 1; i--) scan.push_front(saved[i]);
                end
            end
        end
        if (burst.size() != 0) begin
            tail      = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
        end
        foreach (burst[k]) words_due.push_back(burst[k]);
        burst.delete();
    endfunction

    always @(posedge i_clk) begin : watch
        dest_word_t want;
        if (!i_rst_n) begin
            buf_size  = DEST_SIZE_RESET;
            clear_partial();
            copied    = 0;
            truncated = 1'b0;
            words_due.delete();
            fails     = 0;
        end else begin
            if (i_cfg_we) buf_size = i_cfg_data;
            if (i_src_valid && i_src_ready) copy_source_byte(i_src_byte);
            if (i_dst_valid && i_dst_ready) begin
                if (words_due.size() == 0) begin
                    $error("word 0x%02h arrived with no result pending", i_dst_byte);
                    fails++;
                end else begin
                    want = words_due.pop_front();
                    if (i_dst_byte !== want.data) begin
                        $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, i_dst_byte);
                        fails++;
                    end
                    if (i_dst_term !== want.term) begin
                        $error("is_terminator: expected %0b, actual %0b", want.term, i_dst_term);
                        fails++;
                    end
                    if (i_dst_last !== want.last) begin
                        $error("last_of_run: expected %0b, actual %0b", want.last, i_dst_last);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= words_due.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/tb_utf8_boundary_truncating_copy.sv
// Top of the UTF-8 truncating copy testbench: stimulus, flow control and verdict.
module tb_utf8_boundary_truncating_copy;
    timeunit 1ns;
    timeprecision 1ps;
    import ubtc_pkg::*;

    localparam int unsigned RANDOM_BYTES = 424;
    localparam int unsigned MAX_WAIT     = 14;
    // Two register stages from source word to first output word, plus margin.
    localparam int unsigned TAIL_CYCLES  = 4;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              dest_size_we = 1'b0;
    logic [SIZE_W-1:0] dest_size    = '0;
    logic              src_valid    = 1'b0;
    logic              src_ready;
    logic [7:0]        src_byte     = 8'h00;
    logic              dst_valid;
    logic              dst_ready    = 1'b0;
    logic [7:0]        dst_byte;
    logic              dst_last;
    logic              dst_term;

    int unsigned pending;
    int unsigned fail_count;
    int unsigned bytes_sent = 0;
    bit          steady_src = 1'b0;
    bit          steady_dst = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    utf8_boundary_truncating_copy dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_dest_size_we (dest_size_we),
        .i_dest_size    (dest_size),
        .s_axis_tvalid  (src_valid),
        .s_axis_tready  (src_ready),
        .s_axis_tdata   (src_byte),     // [7:0] in_byte
        .m_axis_tvalid  (dst_valid),
        .m_axis_tready  (dst_ready),
        .m_axis_tdata   (dst_byte),     // [7:0] out_byte
        .m_axis_tlast   (dst_last),     // last_of_run
        .m_axis_tuser   (dst_term)      // [0] is_terminator
    );

    utf8_copy_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (dest_size_we),
        .i_cfg_data   (dest_size),
        .i_src_valid  (src_valid),
        .i_src_ready  (src_ready),
        .i_src_byte   (src_byte),
        .i_dst_valid  (dst_valid),
        .i_dst_ready  (dst_ready),
        .i_dst_byte   (dst_byte),
        .i_dst_last   (dst_last),
        .i_dst_term   (dst_term),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Idle cycles before the next word; none at all while a side runs steady.
    function automatic int unsigned draw_wait(bit steady);
        if (steady || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Drive one source word after a random gap and hold it until accepted.
    // With no gap, tvalid simply stays high and only tdata moves.
    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        gap = draw_wait(steady_src);
        if (gap != 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_byte  <= b;
        do @(posedge clk); while (!src_ready);
        bytes_sent++;
    endtask

    task automatic send_script(input logic [7:0] list [$]);
        foreach (list[k]) send_byte(list[k]);
    endtask

    // Hold the source off until every expected word is out. A held lead byte
    // yields nothing, so pending alone may miss it; a tail wait follows.
    task automatic wait_idle();
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Write the buffer size only from idle; this may land in the middle of a string.
    task automatic set_size(logic [SIZE_W-1:0] v);
        wait_idle();
        dest_size_we <= 1'b1;
        dest_size    <= v;
        @(posedge clk);
        dest_size_we <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 13))
            0:       return '0;
            1:       return SIZE_W'(1);
            2:       return SIZE_W'(2);
            3, 4:    return SIZE_W'($urandom_range(3, 12));
            5, 6:    return SIZE_W'($urandom_range(13, 40));
            7:       return DEST_SIZE_CAP;
            8:       return '1;
            9:       return SIZE_W'(MAX_DEST_SIZE + 1);
            10:      return SIZE_W'($urandom_range(41, 8190));
            default: return DEST_SIZE_RESET;
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return CONT_TAG | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] non_cont();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(1, 8'h7F));
        return 8'($urandom_range(8'hC0, 8'hFF));
    endfunction

    // Lead of a 2-, 3- or 4-byte sequence, biased toward the leads with range checks.
    function automatic logic [7:0] lead_byte(int unsigned span);
        case (span)
            2: return 8'($urandom_range(LEAD2_LO, LEAD2_HI));
            3: begin
                case ($urandom_range(0, 3))
                    0:       return LEAD3_LO;
                    1:       return SURR_LEAD;
                    default: return 8'($urandom_range(LEAD3_LO, LEAD3_HI));
                endcase
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       return LEAD4_LO;
                    1:       return LEAD4_HI;
                    default: return 8'($urandom_range(LEAD4_LO, LEAD4_HI));
                endcase
            end
        endcase
    endfunction

    // Second byte that the lead accepts.
    function automatic logic [7:0] good_second(logic [7:0] lead);
        case (lead)
            LEAD3_LO:  return 8'($urandom_range(SECOND_A0, 8'hBF));
            SURR_LEAD: return 8'($urandom_range(CONT_TAG, 8'h9F));
            LEAD4_LO:  return 8'($urandom_range(SECOND_90, 8'hBF));
            LEAD4_HI:  return 8'($urandom_range(CONT_TAG, 8'h8F));
            default:   return cont_byte();
        endcase
    endfunction

    // Byte in the overlong, surrogate or above-range gap, or else a non-continuation.
    function automatic logic [7:0] bad_second(logic [7:0] lead);
        case (lead)
            LEAD3_LO:  return 8'($urandom_range(CONT_TAG, 8'h9F));
            SURR_LEAD: return 8'($urandom_range(SECOND_A0, 8'hBF));
            LEAD4_LO:  return 8'($urandom_range(CONT_TAG, 8'h8F));
            LEAD4_HI:  return 8'($urandom_range(SECOND_90, 8'hBF));
            default:   return non_cont();
        endcase
    endfunction

    // Send a lead followed by `good` accepted followers.
    task automatic send_prefix(logic [7:0] lead, int unsigned good);
        int unsigned k;
        send_byte(lead);
        for (k = 0; k < good; k++) send_byte(k == 0 ? good_second(lead) : cont_byte());
    endtask

    // One random unit: a zero byte, or most often a well-formed sequence, then broken
    // ones, lone bytes, strings cut off mid-sequence and raw noise.
    task automatic send_random_unit(int unsigned end_weight);
        int unsigned pick;
        int unsigned span;
        int unsigned good;
        logic [7:0]  lead;
        pick = $urandom_range(0, 99);
        span = $urandom_range(2, 4);
        good = $urandom_range(0, span - 2);
        lead = lead_byte(span);
        if (pick < end_weight) begin
            send_byte(8'h00);
        end else if (pick < 60) begin
            if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(1, 8'h7F)));
            else send_prefix(lead, span - 1);
        end else if (pick < 78) begin
            send_prefix(lead, good);
            if (good == 0 && $urandom_range(0, 1) == 0) send_byte(bad_second(lead));
            else send_byte(non_cont());
        end else if (pick < 88) begin
            case ($urandom_range(0, 2))
                0:       send_byte(8'($urandom_range(8'hC0, 8'hC1)));
                1:       send_byte(8'($urandom_range(8'hF5, 8'hFF)));
                default: send_byte(cont_byte());
            endcase
        end else if (pick < 95) begin
            // String end while a sequence is still held.
            send_prefix(lead, good);
            send_byte(8'h00);
        end else begin
            send_byte(8'($urandom_range(1, 255)));
        end
    endtask

    // Sink: stall a random number of cycles before each word, in spells of
    // steady acceptance now and then.
    initial begin : sink
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        forever begin
            if (taken % 40 == 0) steady_dst = ($urandom_range(0, 3) == 0);
            stall = draw_wait(steady_dst);
            if (stall != 0) begin
                dst_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            dst_ready <= 1'b1;
            do @(posedge clk); while (!dst_valid);
            taken++;
        end
    end

    initial begin : source
        logic [7:0]        script[$];
        logic [SIZE_W-1:0] size;
        int unsigned       budget;
        int unsigned       random_goal;
        int unsigned       end_weight;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset size of 64 bytes; every byte class, each malformed form,
        // lone leads, a stray continuation and a string end that flushes a held lead.
        script = {8'h41, 8'hFF, 8'hC2, 8'hA9, 8'hE0, 8'hA0, 8'h80, 8'hE0, 8'h9F,
                  8'hED, 8'hA0, 8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h90, 8'hC1,
                  8'h80, 8'hC2, 8'h41, 8'hE1, 8'h80, 8'h00};
        send_script(script);

        // Zero size: nothing at all, not even the terminator.
        set_size('0);
        script = {8'h41, 8'h00};
        send_script(script);

        // Room for three bytes: after one ASCII byte the 3-byte unit no longer
        // fits and stops the copy, the following byte is ignored, the
        // terminator still comes.
        set_size(SIZE_W'(4));
        script = {8'h41, 8'hE2, 8'h82, 8'hAC, 8'h42, 8'h00};
        send_script(script);

        // Size above the cap, with an overlong 4-byte lead.
        set_size('1);
        script = {8'hF0, 8'h8F, 8'h01, 8'h00};
        send_script(script);

        // Random phases, each under a fresh size; phases end at random points,
        // so many size changes land in the middle of a string.
        random_goal = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_goal) begin
            size = pick_size();
            set_size(size);
            steady_src = ($urandom_range(0, 3) == 0);
            // End strings sooner where the buffer fills fast.
            end_weight = (size <= 16) ? 25 : 8;
            budget = bytes_sent + $urandom_range(30, 70);
            while (bytes_sent < budget) begin
                send_random_unit(end_weight);
                if ($urandom_range(0, 59) == 0) wait_idle();
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("tb_utf8_boundary_truncating_copy: PASS");
        end else begin
            $display("tb_utf8_boundary_truncating_copy: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #10ms;
        $display("tb_utf8_boundary_truncating_copy: FAIL");
        $finish;
    end

endmodule
